// ----- rtl/ptr_pkg.sv -----
//------------------------------------------------------------------------------
// ptr_pkg
// Shared constants, types and helpers of the point translate/rotate block.
//------------------------------------------------------------------------------
package ptr_pkg;

  localparam int COORD_WIDTH_DEF    = 32;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int ANGLE_WIDTH        = 26;
  localparam int CORDIC_STEPS       = 18;
  localparam int WORK_FRAC          = 30;
  localparam int WORK_WIDTH         = 34;
  localparam int ZW                 = 27;

  localparam logic signed [ZW-1:0] DEG_FULL    = 27'sd23592960;
  localparam logic signed [ZW-1:0] DEG_HALF    = 27'sd11796480;
  localparam logic signed [ZW-1:0] DEG_QUARTER = 27'sd5898240;
  localparam logic signed [WORK_WIDTH-1:0] CORDIC_GAIN = 34'sd652032874;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_ROLL     = 3'd3,
    REG_PITCH    = 3'd4,
    REG_YAW      = 3'd5
  } reg_idx_t;

  // Pipeline control between the datapath stages.
  typedef struct packed {
    logic valid;
  } stage_ctl_t;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0:  atan_deg = 27'sd2949120;
      5'd1:  atan_deg = 27'sd1740967;
      5'd2:  atan_deg = 27'sd919879;
      5'd3:  atan_deg = 27'sd466945;
      5'd4:  atan_deg = 27'sd234379;
      5'd5:  atan_deg = 27'sd117304;
      5'd6:  atan_deg = 27'sd58666;
      5'd7:  atan_deg = 27'sd29335;
      5'd8:  atan_deg = 27'sd14668;
      5'd9:  atan_deg = 27'sd7334;
      5'd10: atan_deg = 27'sd3667;
      5'd11: atan_deg = 27'sd1833;
      5'd12: atan_deg = 27'sd917;
      5'd13: atan_deg = 27'sd458;
      5'd14: atan_deg = 27'sd229;
      5'd15: atan_deg = 27'sd115;
      5'd16: atan_deg = 27'sd57;
      5'd17: atan_deg = 27'sd29;
      default: atan_deg = '0;
    endcase
  endfunction

endpackage

// ----- rtl/point_translate_rotate.sv -----
//------------------------------------------------------------------------------
// point_translate_rotate
// Translates a stream of 3D points and rotates them by a Z-Y-X Euler matrix.
//------------------------------------------------------------------------------
// Each accepted input word passes stages s0 to s3 and then the output register.
// Throughput: one point per cycle; the pipeline advances whenever the output
// register is empty or being drained.
// Writing an angle starts a coefficient build in the shared CORDIC unit;
// in_tready stays low until the new matrix is in place.
// Reset (synchronous, rst_n low): offsets and angles zero, identity matrix.
module point_translate_rotate
  import ptr_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // point_x, point_y, point_z from bit 0 up
  input  logic [3*COORD_WIDTH-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // out_x, out_y, out_z from bit 0 up
  output logic [3*COORD_WIDTH-1:0] out_tdata,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [4:0]               cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = CW + DW;
  localparam int SW = PW + 2;
  localparam int NS = 4;

  logic signed [COORD_WIDTH-1:0] off_r [3];
  logic signed [ANGLE_WIDTH-1:0] roll_r, pitch_r, yaw_r;
  logic                          wr_en, start_r;
  logic [2:0]                    wr_idx;
  logic                          busy;
  logic signed [CW-1:0]          coef [9];

  assign cfg_pready = 1'b1;
  assign wr_en  = cfg_psel && cfg_penable && cfg_pwrite;
  assign wr_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) off_r[k] <= '0;
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      start_r <= 1'b0;
    end else begin
      start_r <= wr_en && cfg_paddr[1:0] == 2'b00 &&
                 (wr_idx inside {REG_ROLL, REG_PITCH, REG_YAW});
      if (wr_en && cfg_paddr[1:0] == 2'b00) begin
        case (wr_idx)
          REG_OFFSET_X: off_r[0] <= COORD_WIDTH'(signed'(cfg_pwdata));
          REG_OFFSET_Y: off_r[1] <= COORD_WIDTH'(signed'(cfg_pwdata));
          REG_OFFSET_Z: off_r[2] <= COORD_WIDTH'(signed'(cfg_pwdata));
          REG_ROLL:  roll_r  <= cfg_pwdata[ANGLE_WIDTH-1:0];
          REG_PITCH: pitch_r <= cfg_pwdata[ANGLE_WIDTH-1:0];
          REG_YAW:   yaw_r   <= cfg_pwdata[ANGLE_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (wr_idx)
      REG_OFFSET_X: cfg_prdata = 32'(off_r[0]);
      REG_OFFSET_Y: cfg_prdata = 32'(off_r[1]);
      REG_OFFSET_Z: cfg_prdata = 32'(off_r[2]);
      REG_ROLL:     cfg_prdata = 32'(roll_r);
      REG_PITCH:    cfg_prdata = 32'(pitch_r);
      REG_YAW:      cfg_prdata = 32'(yaw_r);
      default: ;
    endcase
  end

  ptr_coef #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .roll  (roll_r),
    .pitch (pitch_r),
    .yaw   (yaw_r),
    .busy  (busy),
    .coef  (coef)
  );

  // Pipeline: s0 subtract, s1 products, s2 row sums, s3 round/saturate, then
  // the output register. All stages move together on adv.
  stage_ctl_t               ctl_r [NS];
  logic                     adv;
  logic signed [DW-1:0]     d_r  [3];
  logic signed [PW-1:0]     p_r  [9];
  logic signed [SW-1:0]     s_r  [3];
  logic [COORD_WIDTH-1:0]   q_r  [3];
  logic                     ov_r;
  logic [3*COORD_WIDTH-1:0] od_r;

  // New words wait while the coefficients are being rebuilt.
  assign adv       = !ov_r || out_tready;
  assign in_tready = adv && !busy && !start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) ctl_r[k].valid <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      ctl_r[0].valid <= in_tvalid && in_tready;
      for (int k = 1; k < NS; k++) ctl_r[k].valid <= ctl_r[k-1].valid;
      ov_r <= ctl_r[NS-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++)
        d_r[k] <= DW'(signed'(in_tdata[k*COORD_WIDTH +: COORD_WIDTH])) - DW'(off_r[k]);
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          p_r[3*r+k] <= PW'(coef[3*r+k]) * PW'(d_r[k]);
      for (int r = 0; r < 3; r++)
        s_r[r] <= SW'(p_r[3*r]) + SW'(p_r[3*r+1]) + SW'(p_r[3*r+2])
                  + (SW'(1) <<< (COEF_FRAC_BITS - 1));
      for (int r = 0; r < 3; r++) begin
        logic signed [SW-1:0] v;
        logic signed [SW-1:0] top;
        v   = s_r[r] >>> COEF_FRAC_BITS;
        top = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
        if (v > top)            q_r[r] <= COORD_WIDTH'(top);
        else if (v < -top - 1)  q_r[r] <= COORD_WIDTH'(-top - 1);
        else                    q_r[r] <= COORD_WIDTH'(v);
      end
      for (int r = 0; r < 3; r++) od_r[r*COORD_WIDTH +: COORD_WIDTH] <= q_r[r];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r && $stable(od_r))
    else $error("output word lost under stall");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ctl_r[NS-1].valid |=> ov_r)
    else $error("pipeline word dropped");
  a_cfg_start: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |=> busy)
    else $error("angle write did not start a build");

endmodule

// ----- rtl/ptr_coef.sv -----
//------------------------------------------------------------------------------
// ptr_coef
// Builds the nine rotation coefficients from the three angles with one
// shared CORDIC unit (one micro-rotation per cycle) and one multiplier.
//------------------------------------------------------------------------------
module ptr_coef
  import ptr_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int CW = COEF_FRAC_BITS + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ANGLE_WIDTH-1:0] roll,
  input  logic signed [ANGLE_WIDTH-1:0] pitch,
  input  logic signed [ANGLE_WIDTH-1:0] yaw,
  output logic                          busy,
  output logic signed [CW-1:0]          coef [9]
);

  typedef enum logic [2:0] {ST_IDLE, ST_RED1, ST_RED2, ST_ITER, ST_STORE, ST_MUL}
    state_t;

  localparam int SH = WORK_FRAC - COEF_FRAC_BITS;
  localparam int PW = 2 * WORK_WIDTH;

  state_t                        state_r;
  logic                          pending_r;
  logic [1:0]                    ang_r;
  logic [4:0]                    it_r;
  logic [3:0]                    mstep_r;
  logic signed [ZW-1:0]          z_r;
  logic                          neg_r;
  logic signed [WORK_WIDTH-1:0]  x_r, y_r;
  logic signed [WORK_WIDTH-1:0]  sv_r [3];
  logic signed [WORK_WIDTH-1:0]  cv_r [3];
  logic signed [WORK_WIDTH-1:0]  t_r  [9];
  logic signed [WORK_WIDTH-1:0]  tmp_r [4];
  logic signed [CW-1:0]          coef_r [9];

  logic signed [ANGLE_WIDTH-1:0] ang_sel;
  logic signed [ZW-1:0]          rem_a;
  logic signed [WORK_WIDTH-1:0]  dx, dy;
  logic signed [WORK_WIDTH-1:0]  ma, mb, mq;
  logic signed [PW-1:0]          mp;

  always_comb begin
    case (ang_r)
      2'd0:    ang_sel = roll;
      2'd1:    ang_sel = pitch;
      default: ang_sel = yaw;
    endcase
  end

  // Truncating remainder by a full turn: the angle register spans less than
  // two turns either way, so one correction suffices.
  always_comb begin
    logic signed [ZW-1:0] a;
    a = ZW'(ang_sel);
    if (a >= DEG_FULL)       a = a - DEG_FULL;
    else if (a <= -DEG_FULL) a = a + DEG_FULL;
    rem_a = a;
  end

  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;

  // Multiply sequence: mstep selects operands, result Q.30 rounded half up.
  always_comb begin
    ma = '0;
    mb = '0;
    case (mstep_r)
      4'd0:  begin ma = cv_r[2];  mb = cv_r[1]; end
      4'd1:  begin ma = cv_r[2];  mb = sv_r[1]; end
      4'd2:  begin ma = sv_r[2];  mb = sv_r[1]; end
      4'd3:  begin ma = sv_r[2];  mb = cv_r[1]; end
      4'd4:  begin ma = cv_r[1];  mb = sv_r[0]; end
      4'd5:  begin ma = cv_r[1];  mb = cv_r[0]; end
      4'd6:  begin ma = tmp_r[0]; mb = sv_r[0]; end
      4'd7:  begin ma = tmp_r[0]; mb = cv_r[0]; end
      4'd8:  begin ma = tmp_r[1]; mb = sv_r[0]; end
      4'd9:  begin ma = tmp_r[1]; mb = cv_r[0]; end
      4'd10: begin ma = sv_r[2];  mb = cv_r[0]; end
      4'd11: begin ma = sv_r[2];  mb = sv_r[0]; end
      4'd12: begin ma = cv_r[2];  mb = cv_r[0]; end
      4'd13: begin ma = cv_r[2];  mb = sv_r[0]; end
      default: ;
    endcase
    mp = ma * mb + (PW'(1) <<< (WORK_FRAC - 1));
    mq = WORK_WIDTH'(mp >>> WORK_FRAC);
  end

  function automatic logic signed [CW-1:0] to_coef(input logic signed [WORK_WIDTH-1:0] v);
    logic signed [WORK_WIDTH:0] r;
    logic signed [WORK_WIDTH:0] lim;
    r   = ((WORK_WIDTH+1)'(v) + ((WORK_WIDTH+1)'(1) <<< SH) / 2) >>> SH;
    lim = (WORK_WIDTH+1)'(1) <<< (COEF_FRAC_BITS + 1);
    if (r > lim - 1)   to_coef = CW'(lim - 1);
    else if (r < -lim) to_coef = CW'(-lim);
    else               to_coef = CW'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pending_r <= 1'b0;
      ang_r     <= '0;
      it_r      <= '0;
      mstep_r   <= '0;
      for (int k = 0; k < 9; k++)
        coef_r[k] <= (k % 4 == 0) ? CW'(1) <<< COEF_FRAC_BITS : '0;
    end else begin
      // An angle written during a build triggers one more build afterwards.
      pending_r <= (state_r != ST_IDLE) ? (pending_r || start) : 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start || pending_r) begin
            ang_r   <= 2'd0;
            state_r <= ST_RED1;
          end
        end
        ST_RED1: begin
          z_r     <= rem_a;
          state_r <= ST_RED2;
        end
        ST_RED2: begin
          logic signed [ZW-1:0] r;
          logic                 n;
          r = z_r;
          n = 1'b0;
          if (r < 0) r = r + DEG_FULL;
          if (r >= DEG_HALF) r = r - DEG_FULL;
          if (r > DEG_QUARTER) begin
            r = r - DEG_HALF;
            n = 1'b1;
          end else if (r < -DEG_QUARTER) begin
            r = r + DEG_HALF;
            n = 1'b1;
          end
          neg_r   <= n;
          z_r     <= r;
          x_r     <= CORDIC_GAIN;
          y_r     <= '0;
          it_r    <= '0;
          state_r <= ST_ITER;
        end
        ST_ITER: begin
          if (!z_r[ZW-1]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - atan_deg(it_r);
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + atan_deg(it_r);
          end
          if (it_r == 5'(CORDIC_STEPS - 1)) state_r <= ST_STORE;
          it_r <= it_r + 5'd1;
        end
        ST_STORE: begin
          sv_r[ang_r] <= neg_r ? -y_r : y_r;
          cv_r[ang_r] <= neg_r ? -x_r : x_r;
          if (ang_r == 2'd2) begin
            mstep_r <= '0;
            state_r <= ST_MUL;
          end else begin
            ang_r   <= ang_r + 2'd1;
            state_r <= ST_RED1;
          end
        end
        ST_MUL: begin
          case (mstep_r)
            4'd0:  t_r[0]   <= mq;
            4'd1:  tmp_r[0] <= mq;
            4'd2:  tmp_r[1] <= mq;
            4'd3:  t_r[3]   <= mq;
            4'd4:  t_r[7]   <= mq;
            4'd5:  t_r[8]   <= mq;
            4'd6:  t_r[1]   <= mq;
            4'd7:  t_r[2]   <= mq;
            4'd8:  t_r[4]   <= mq;
            4'd9:  t_r[5]   <= mq;
            4'd10: t_r[1]   <= t_r[1] - mq;
            4'd11: t_r[2]   <= t_r[2] + mq;
            4'd12: t_r[4]   <= t_r[4] + mq;
            4'd13: t_r[5]   <= t_r[5] - mq;
            default: ;
          endcase
          if (mstep_r == 4'd14) begin
            coef_r[0] <= to_coef(t_r[0]);
            coef_r[1] <= to_coef(t_r[1]);
            coef_r[2] <= to_coef(t_r[2]);
            coef_r[3] <= to_coef(t_r[3]);
            coef_r[4] <= to_coef(t_r[4]);
            coef_r[5] <= to_coef(t_r[5]);
            coef_r[6] <= to_coef(-sv_r[1]);
            coef_r[7] <= to_coef(t_r[7]);
            coef_r[8] <= to_coef(t_r[8]);
            state_r   <= ST_IDLE;
          end
          mstep_r <= mstep_r + 4'd1;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE) || pending_r;
  assign coef = coef_r;

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ITER |-> it_r < 5'(CORDIC_STEPS))
    else $error("CORDIC iteration count out of range");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && start |=> busy)
    else $error("coefficient build did not start");
  a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> mstep_r <= 4'd14)
    else $error("multiply sequence out of range");

endmodule
